>>> hw/rtl/utf8_stream_decoder_defines.svh
// Assertion macros for the UTF-8 stream decoder checker.
// Needs clk and rst_n in the scope where the macros are used.
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

// Checked only outside reset.
`define U8SD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define U8SD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/u8sd_pkg.sv
// Shared widths and constants for the UTF-8 stream decoder.
// No dependencies; used by the top level and its checker.
package u8sd_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int LEN_W  = 3;
    localparam int LEFT_W = 2;

    localparam logic [LEN_W-1:0] LEN_INVALID = 3'd0;
    localparam logic [LEN_W-1:0] LEN_ONE     = 3'd1;
    localparam logic [LEN_W-1:0] LEN_TWO     = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THREE   = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FOUR    = 3'd4;

    localparam logic [CP_W-1:0] CP_SPACE     = 21'h20;
    localparam logic [CP_W-1:0] CP_DEL       = 21'h7F;
    localparam logic [CP_W-1:0] CP_C1_FIRST  = 21'h80;
    localparam logic [CP_W-1:0] CP_C1_LAST   = 21'h9F;
    localparam logic [CP_W-1:0] CP_ASCII_END = 21'h80;

    typedef logic [CP_W-1:0]  cp_t;
    typedef logic [LEN_W-1:0] len_t;

endpackage

>>> hw/rtl/utf8_stream_decoder.sv
// UTF-8 stream decoder top level: one byte in, at most one code point out.
// Depends on u8sd_pkg.
//
//  channel | valid     | ready     | payload
//  --------+-----------+-----------+------------------------------------------
//  in      | in_valid  | in_ready  | in_byte
//  out     | out_valid | out_ready | code_point, seq_length, printable, is_space
//
// One byte per cycle unless a stalled result holds the input register; the byte
// that finishes a sequence passes the input register, then the result register.
// The sequence state updates as the input register advances into decode.
// A stalled result holds the input register only if that byte makes a result.
// Reset clears the valid flags and the sequence state; no clearing pass.
module utf8_stream_decoder (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [u8sd_pkg::BYTE_W-1:0] in_byte,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [u8sd_pkg::CP_W-1:0]  code_point,
    output logic [u8sd_pkg::LEN_W-1:0] seq_length,
    output logic                      printable,
    output logic                      is_space
);
    import u8sd_pkg::*;

    // input register
    logic              s1_valid_reg, s1_valid_next;
    logic [BYTE_W-1:0] s1_byte_reg;

    // sequence state
    logic [LEFT_W-1:0] bytes_left_reg, bytes_left_next;
    len_t              total_length_reg, total_length_next;
    cp_t               partial_reg, partial_next;

    // result register
    logic out_valid_reg, out_valid_next;
    cp_t  code_point_reg, code_point_next;
    len_t seq_length_reg, seq_length_next;
    logic printable_reg, printable_next;
    logic is_space_reg, is_space_next;

    logic has_result;
    logic out_free;
    logic s1_fire;
    cp_t  ascii_cp;
    cp_t  joined_cp;
    logic is_cont;

    assign out_free = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && (!has_result || out_free);
    assign in_ready = !s1_valid_reg || s1_fire;

    assign ascii_cp  = {{(CP_W-BYTE_W){1'b0}}, s1_byte_reg};
    assign joined_cp = {partial_reg[CP_W-7:0], s1_byte_reg[5:0]};
    assign is_cont   = (s1_byte_reg[7:6] == 2'b10);

    always_comb
    begin
        has_result        = 1'b0;
        bytes_left_next   = bytes_left_reg;
        total_length_next = total_length_reg;
        partial_next      = partial_reg;
        code_point_next   = '0;
        seq_length_next   = LEN_INVALID;
        printable_next    = 1'b0;
        is_space_next     = 1'b0;

        if (bytes_left_reg == '0)
        begin
            priority if (s1_byte_reg[7] == 1'b0)
            begin
                has_result      = 1'b1;
                code_point_next = ascii_cp;
                seq_length_next = LEN_ONE;
                printable_next  = (ascii_cp >= CP_SPACE) && (ascii_cp < CP_DEL);
                is_space_next   = (ascii_cp == CP_SPACE) ||
                                  ((s1_byte_reg >= 8'h09) && (s1_byte_reg <= 8'h0D));
            end
            else if (s1_byte_reg[7:5] == 3'b110)
            begin
                partial_next      = {{(CP_W-5){1'b0}}, s1_byte_reg[4:0]};
                total_length_next = LEN_TWO;
                bytes_left_next   = 2'd1;
            end
            else if (s1_byte_reg[7:4] == 4'b1110)
            begin
                partial_next      = {{(CP_W-4){1'b0}}, s1_byte_reg[3:0]};
                total_length_next = LEN_THREE;
                bytes_left_next   = 2'd2;
            end
            else if (s1_byte_reg[7:3] == 5'b11110)
            begin
                partial_next      = {{(CP_W-3){1'b0}}, s1_byte_reg[2:0]};
                total_length_next = LEN_FOUR;
                bytes_left_next   = 2'd3;
            end
            else
            begin
                // invalid lead: all-zero result
                has_result = 1'b1;
            end
        end
        else if (!is_cont)
        begin
            // drop the open sequence, byte is consumed
            has_result        = 1'b1;
            bytes_left_next   = '0;
            total_length_next = LEN_INVALID;
            partial_next      = '0;
        end
        else if (bytes_left_reg == 2'd1)
        begin
            has_result        = 1'b1;
            code_point_next   = joined_cp;
            seq_length_next   = total_length_reg;
            printable_next    = (joined_cp >= CP_SPACE) && (joined_cp != CP_DEL) &&
                                ((joined_cp < CP_C1_FIRST) || (joined_cp > CP_C1_LAST));
            bytes_left_next   = '0;
            total_length_next = LEN_INVALID;
            partial_next      = '0;
        end
        else
        begin
            partial_next    = joined_cp;
            bytes_left_next = bytes_left_reg - 2'd1;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_ready)
        begin
            s1_valid_next = in_valid;
        end
    end

    always_comb
    begin
        if (s1_fire && has_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            bytes_left_reg   <= '0;
            total_length_reg <= LEN_INVALID;
            partial_reg      <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_fire)
            begin
                bytes_left_reg   <= bytes_left_next;
                total_length_reg <= total_length_next;
                partial_reg      <= partial_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg <= in_byte;
        end
        if (s1_fire && has_result)
        begin
            code_point_reg <= code_point_next;
            seq_length_reg <= seq_length_next;
            printable_reg  <= printable_next;
            is_space_reg   <= is_space_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign code_point = code_point_reg;
    assign seq_length = seq_length_reg;
    assign printable  = printable_reg;
    assign is_space   = is_space_reg;

endmodule

>>> hw/rtl/u8sd_checker.sv
// Port-level checks for the UTF-8 stream decoder, bound to the top level.
// Depends on u8sd_pkg and utf8_stream_decoder_defines.svh.
`include "utf8_stream_decoder_defines.svh"

module u8sd_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic [u8sd_pkg::BYTE_W-1:0] in_byte,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [u8sd_pkg::CP_W-1:0]   code_point,
    input logic [u8sd_pkg::LEN_W-1:0]  seq_length,
    input logic                        printable,
    input logic                        is_space
);
    import u8sd_pkg::*;

    logic unused_in;
    assign unused_in = in_valid ^ in_ready ^ (^in_byte);

    // reset may first take effect at the edge where it is seen, so check the edge after
    `U8SD_ASSERT_ALWAYS(a_no_out_in_reset, !rst_n |=> !out_valid, "result valid during reset")
    `U8SD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(code_point), "stalled result dropped or changed")
    `U8SD_ASSERT(a_len_range, out_valid |-> seq_length <= LEN_FOUR, "length out of range")
    `U8SD_ASSERT(a_invalid_zero, out_valid && seq_length == LEN_INVALID |-> code_point == '0 && !printable && !is_space, "invalid transfer has nonzero fields")
    `U8SD_ASSERT(a_space_ascii, out_valid && is_space |-> seq_length == LEN_ONE && code_point <= CP_SPACE, "space flag on non-ASCII transfer")

endmodule

bind utf8_stream_decoder u8sd_checker u_u8sd_checker (.*);
